/* rtl/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// Serial frame deframer package
// Shared constants, register indexes, frame positions and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

  localparam int unsigned MAX_PAYLOAD = 256;
  localparam int unsigned HDR_BYTES   = 8;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_VERSION = 2'd2;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] EXP_VERSION_RST = 8'h00;

  // Byte positions within the frame header.
  localparam logic [POS_W-1:0] POS_HUNT   = 9'd0;
  localparam logic [POS_W-1:0] POS_SYNC2  = 9'd1;
  localparam logic [POS_W-1:0] POS_VER    = 9'd2;
  localparam logic [POS_W-1:0] POS_SEQ_HI = 9'd3;
  localparam logic [POS_W-1:0] POS_SEQ_LO = 9'd4;
  localparam logic [POS_W-1:0] POS_CMD    = 9'd5;
  localparam logic [POS_W-1:0] POS_LEN_HI = 9'd6;
  localparam logic [POS_W-1:0] POS_LEN_LO = 9'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_index;
    logic              is_end;
    logic              frame_ok;
    logic [SEQ_W-1:0]  seq_number;
    logic [BYTE_W-1:0] command;
    logic [LEN_W-1:0]  payload_length;
  } result_t;

endpackage : sfd_pkg

`default_nettype wire

/* rtl/sfd_in_stage.sv */
// ----------------------------------------------------------------------------
// Deframer input stage
// Registers one received byte and holds it until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_in_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire logic [sfd_pkg::BYTE_W-1:0] in_rx_byte,
  output      logic                      hold_valid,
  output      logic [sfd_pkg::BYTE_W-1:0] hold_byte,
  input  wire logic                      hold_take
);
  import sfd_pkg::*;

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              load;

  // The register can be refilled in the same cycle its item is consumed.
  assign in_stall  = valid_r && !hold_take;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load || (valid_r && !hold_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

endmodule : sfd_in_stage

`default_nettype wire

/* rtl/sfd_parser.sv */
// ----------------------------------------------------------------------------
// Deframer frame parser
// Holds frame state and config; decodes one byte per cycle while res_free.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_parser (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sfd_pkg::BYTE_W-1:0]    cfg_data,
  input  wire logic                         byte_valid,
  input  wire logic [sfd_pkg::BYTE_W-1:0]    byte_in,
  input  wire logic                         res_free,
  output      logic                         byte_take,
  output      logic                         res_load,
  output      sfd_pkg::result_t             res
);
  import sfd_pkg::*;

  localparam logic [POS_W-1:0]  HDR_POS   = POS_W'(HDR_BYTES);
  localparam logic [POS_W-1:0]  HDR_CHK   = POS_W'(HDR_BYTES + 1);
  localparam logic [SEQ_W-1:0]  MAX_LEN   = SEQ_W'(MAX_PAYLOAD);

  logic [BYTE_W-1:0] sync_first_r, sync_second_r, exp_version_r;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  total_r, total_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic              vmatch_r, vmatch_nxt;

  logic [SEQ_W-1:0]  decl_len;
  logic              at_end;
  logic [BYTE_W-1:0] sum_add;
  logic              emit;

  assign byte_take = byte_valid && res_free;
  assign decl_len  = {total_r[BYTE_W-1:0], byte_in};
  assign at_end    = (total_r == '0) || ({1'b0, pos_r} + 10'd1 >= {1'b0, total_r});
  assign sum_add   = sum_r + byte_in;

  always_comb begin
    pos_nxt    = pos_r + 9'd1;
    total_nxt  = total_r;
    sum_nxt    = sum_add;
    seq_nxt    = seq_r;
    cmd_nxt    = cmd_r;
    vmatch_nxt = vmatch_r;
    emit       = 1'b0;

    res.payload_byte   = byte_in;
    res.payload_index  = BYTE_W'(pos_r - HDR_POS);
    res.is_end         = 1'b0;
    res.frame_ok       = 1'b0;
    res.seq_number     = seq_r;
    res.command        = cmd_r;
    res.payload_length = (total_r >= HDR_CHK) ? (total_r - HDR_CHK) : '0;

    case (pos_r)
      POS_HUNT: begin
        sum_nxt = byte_in;
        pos_nxt = (byte_in == sync_first_r) ? POS_SYNC2 : POS_HUNT;
      end
      POS_SYNC2: begin
        // The second-sync test wins; a stray first-sync byte restarts the frame.
        if (byte_in == sync_second_r) begin
          pos_nxt = POS_VER;
        end else if (byte_in == sync_first_r) begin
          sum_nxt = byte_in;
          pos_nxt = POS_SYNC2;
        end else begin
          sum_nxt   = sum_r;
          pos_nxt   = POS_HUNT;
          total_nxt = '0;
        end
      end
      POS_VER:    vmatch_nxt = (byte_in == exp_version_r);
      POS_SEQ_HI: seq_nxt    = {byte_in, 8'h00};
      POS_SEQ_LO: seq_nxt    = {seq_r[SEQ_W-1:BYTE_W], byte_in};
      POS_CMD:    cmd_nxt    = byte_in;
      POS_LEN_HI: total_nxt  = {1'b0, byte_in};
      POS_LEN_LO: begin
        if (decl_len > MAX_LEN) begin
          sum_nxt   = sum_r;
          pos_nxt   = POS_HUNT;
          total_nxt = '0;
        end else begin
          total_nxt = HDR_CHK + decl_len[LEN_W-1:0];
        end
      end
      default: begin
        emit = 1'b1;
        if (at_end) begin
          res.payload_byte  = '0;
          res.payload_index = '0;
          res.is_end        = 1'b1;
          res.frame_ok      = vmatch_r && (byte_in == sum_r);
          sum_nxt           = sum_r;
          pos_nxt           = POS_HUNT;
          total_nxt         = '0;
        end
      end
    endcase
  end

  assign res_load = byte_take && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
      exp_version_r <= EXP_VERSION_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_data;
        CFG_SYNC_SECOND: sync_second_r <= cfg_data;
        CFG_EXP_VERSION: exp_version_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_HUNT;
      total_r  <= '0;
      sum_r    <= '0;
      seq_r    <= '0;
      cmd_r    <= '0;
      vmatch_r <= 1'b0;
    end else if (byte_take) begin
      pos_r    <= pos_nxt;
      total_r  <= total_nxt;
      sum_r    <= sum_nxt;
      seq_r    <= seq_nxt;
      cmd_r    <= cmd_nxt;
      vmatch_r <= vmatch_nxt;
    end
  end

endmodule : sfd_parser

`default_nettype wire

/* rtl/sfd_out_stage.sv */
// ----------------------------------------------------------------------------
// Deframer output stage
// Result register that holds one item until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             res_load,
  input  wire sfd_pkg::result_t res,
  output      logic             res_free,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      sfd_pkg::result_t out_res
);
  import sfd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign res_free  = !valid_r || !out_stall;
  assign valid_nxt = res_load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule : sfd_out_stage

`default_nettype wire

/* rtl/serial_frame_deframer.sv */
// ----------------------------------------------------------------------------
// Serial frame deframer
// Results are registered in the output stage; header bytes and dropped frames
// give no result. Throughput: one byte per cycle while out_stall is low.
// The input register refills in the cycle the parser consumes its byte.
// Reset (synchronous, active low) restores the default sync and version
// registers and returns the parser to hunting for the first sync byte.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_deframer (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sfd_pkg::BYTE_W-1:0]    cfg_data,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic [sfd_pkg::BYTE_W-1:0]    in_rx_byte,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [sfd_pkg::BYTE_W-1:0]    out_payload_byte,
  output      logic [sfd_pkg::BYTE_W-1:0]    out_payload_index,
  output      logic                         out_is_end,
  output      logic                         out_frame_ok,
  output      logic [sfd_pkg::SEQ_W-1:0]     out_seq_number,
  output      logic [sfd_pkg::BYTE_W-1:0]    out_command,
  output      logic [sfd_pkg::LEN_W-1:0]     out_payload_length
);
  import sfd_pkg::*;

  logic              hold_valid;
  logic [BYTE_W-1:0] hold_byte;
  logic              byte_take;
  logic              res_free;
  logic              res_load;
  result_t           res;
  result_t           out_res;

  sfd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .hold_take  (byte_take)
  );

  sfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_valid (hold_valid),
    .byte_in    (hold_byte),
    .res_free   (res_free),
    .byte_take  (byte_take),
    .res_load   (res_load),
    .res        (res)
  );

  sfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_payload_byte   = out_res.payload_byte;
  assign out_payload_index  = out_res.payload_index;
  assign out_is_end         = out_res.is_end;
  assign out_frame_ok       = out_res.frame_ok;
  assign out_seq_number     = out_res.seq_number;
  assign out_command        = out_res.command;
  assign out_payload_length = out_res.payload_length;

endmodule : serial_frame_deframer

`default_nettype wire

/* tb/sv/serial_frame_deframer_tb.sv */
// ----------------------------------------------------------------------------
// Serial frame deframer testbench
// Feeds received bytes through the valid/stall input channel and checks every
// payload and end-of-frame result against a cycle-free model of the frame
// parser. A short table covers sync hunting, empty and oversize frames and a
// bad version; random framed traffic then runs under several register settings.
// ----------------------------------------------------------------------------
module serial_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  localparam int unsigned GAP_PCT      = 9;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned IDLE_LIMIT   = 1000;

  // Index 3 decodes to no register and must leave the block untouched.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic              typed;
    result_t           res;
  } row_t;

  localparam row_t DIRECTED_ROWS [30] = '{
    // Wrong second byte, then a repeated first sync byte that is reused.
    '{8'h55, 1'b0, '0}, '{8'h12, 1'b0, '0},
    '{8'h55, 1'b0, '0}, '{8'h55, 1'b0, '0}, '{8'hAA, 1'b0, '0},
    // Empty payload: the byte after the length is the checksum.
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h07, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h07, 1'b1, '{8'h00, 8'h00, 1'b1, 1'b1, 16'h0001, 8'h07, 9'd0}},
    // Declared length one above the maximum drops the frame silently.
    '{8'h55, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h01, 1'b0, '0},
    // All-ones version, sequence and command (a wrong version), one-byte payload.
    '{8'h55, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b1, '{8'h00, 8'h00, 1'b1, 1'b0, 16'hFFFF, 8'hFF, 9'd1}}
  };

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [BYTE_W-1:0]    cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [BYTE_W-1:0]    out_payload_byte;
  logic [BYTE_W-1:0]    out_payload_index;
  logic                 out_is_end;
  logic                 out_frame_ok;
  logic [SEQ_W-1:0]     out_seq_number;
  logic [BYTE_W-1:0]    out_command;
  logic [LEN_W-1:0]     out_payload_length;

  // Parser state and register copies of the model.
  logic [POS_W-1:0]  frm_pos   = '0;
  logic [POS_W-1:0]  frm_total = '0;
  logic [BYTE_W-1:0] frm_sum   = '0;
  logic [SEQ_W-1:0]  frm_seq   = '0;
  logic [BYTE_W-1:0] frm_cmd   = '0;
  logic              ver_ok    = 1'b0;
  logic [BYTE_W-1:0] reg_sync_first  = SYNC_FIRST_RST;
  logic [BYTE_W-1:0] reg_sync_second = SYNC_SECOND_RST;
  logic [BYTE_W-1:0] reg_version     = EXP_VERSION_RST;

  row_t        stim_q[$];
  row_t        cur_row = '0;
  result_t     frame_result_q[$];
  bit          no_gaps = 1'b0;
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;

  serial_frame_deframer i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_is_end         (out_is_end),
    .out_frame_ok       (out_frame_ok),
    .out_seq_number     (out_seq_number),
    .out_command        (out_command),
    .out_payload_length (out_payload_length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advances the parser by one byte; returns 1 when the byte yields a result.
  function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output result_t res);
    logic [15:0] dlen;
    bit          hit;
    res = '0;
    hit = 1'b0;
    case (frm_pos)
      POS_HUNT: begin
        if (b == reg_sync_first) begin
          frm_sum = b;
          frm_pos = POS_SYNC2;
        end
      end
      POS_SYNC2: begin
        if (b == reg_sync_second) begin
          frm_sum = frm_sum + b;
          frm_pos = POS_VER;
        end else if (b == reg_sync_first) begin
          frm_sum = b;
        end else begin
          frm_pos   = POS_HUNT;
          frm_total = '0;
        end
      end
      POS_VER, POS_SEQ_HI, POS_SEQ_LO, POS_CMD, POS_LEN_HI: begin
        case (frm_pos)
          POS_VER:    ver_ok = (b == reg_version);
          POS_SEQ_HI: frm_seq = {b, 8'h00};
          POS_SEQ_LO: frm_seq[7:0] = b;
          POS_CMD:    frm_cmd = b;
          default:    frm_total = {1'b0, b};
        endcase
        frm_sum = frm_sum + b;
        frm_pos = frm_pos + 1'b1;
      end
      POS_LEN_LO: begin
        dlen = {frm_total[7:0], b};
        if (dlen > MAX_PAYLOAD) begin
          frm_pos   = POS_HUNT;
          frm_total = '0;
        end else begin
          frm_total = POS_W'(HDR_BYTES + dlen + 1);
          frm_sum   = frm_sum + b;
          frm_pos   = POS_W'(HDR_BYTES);
        end
      end
      default: begin
        hit = 1'b1;
        res.seq_number     = frm_seq;
        res.command        = frm_cmd;
        res.payload_length = (frm_total >= HDR_BYTES + 1) ?
                             LEN_W'(frm_total - HDR_BYTES - 1) : '0;
        if (frm_total == 0 || frm_pos + 1 >= frm_total) begin
          res.is_end   = 1'b1;
          res.frame_ok = ver_ok && (b == frm_sum);
          frm_pos      = POS_HUNT;
          frm_total    = '0;
        end else begin
          res.payload_byte  = b;
          res.payload_index = BYTE_W'(frm_pos - HDR_BYTES);
          frm_sum = frm_sum + b;
          frm_pos = frm_pos + 1'b1;
        end
      end
    endcase
    return hit;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR: %0t %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SYNC_FIRST:  reg_sync_first  = val;
      CFG_SYNC_SECOND: reg_sync_second = val;
      CFG_EXP_VERSION: reg_version     = val;
      default: ;
    endcase
  endtask

  // Queues one frame under the current registers. keep > 0 cuts it short.
  task automatic queue_frame(input int unsigned len, input bit bad_ver, input bit bad_sum,
                             input int unsigned keep);
    logic [BYTE_W-1:0] bytes[$];
    logic [BYTE_W-1:0] sum;
    logic [SEQ_W-1:0]  seq;
    seq   = SEQ_W'($urandom);
    bytes = '{reg_sync_first, reg_sync_second,
              bad_ver ? reg_version + BYTE_W'($urandom_range(1, 255)) : reg_version,
              seq[15:8], seq[7:0], BYTE_W'($urandom), BYTE_W'(len >> 8), BYTE_W'(len)};
    if (len <= MAX_PAYLOAD) begin
      repeat (len) bytes.push_back(BYTE_W'($urandom));
      sum = '0;
      foreach (bytes[i]) sum = sum + bytes[i];
      bytes.push_back(bad_sum ? sum + BYTE_W'($urandom_range(1, 255)) : sum);
    end
    if (keep != 0 && keep < bytes.size()) bytes = bytes[0:keep-1];
    foreach (bytes[i]) stim_q.push_back('{bytes[i], 1'b0, '0});
  endtask

  task automatic queue_random_traffic(input int unsigned n_items);
    int unsigned target;
    int unsigned sel;
    int unsigned len;
    target = stim_q.size() + n_items;
    while (stim_q.size() < target) begin
      sel = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      if (sel < 60)
        queue_frame(len, 1'b0, 1'b0, 0);
      else if (sel < 68)
        queue_frame(len, 1'b0, 1'b1, 0);
      else if (sel < 74)
        queue_frame(len, 1'b1, 1'b0, 0);
      else if (sel < 80)
        queue_frame($urandom_range(0, 1) ? MAX_PAYLOAD + 1 :
                    $urandom_range(MAX_PAYLOAD + 1, 65535), 1'b0, 1'b0, 0);
      else if (sel < 88)
        queue_frame(len, 1'b0, 1'b0, $urandom_range(1, len + HDR_BYTES));
      else
        repeat ($urandom_range(1, 4)) stim_q.push_back('{BYTE_W'($urandom), 1'b0, '0});
    end
  endtask

  // Header bytes give no result, so a short pause follows the last result.
  task automatic wait_idle();
    while (stim_q.size() != 0 || in_valid || frame_result_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : feed_bytes
    result_t pred;
    bit      hit;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        hit = deframe_byte(cur_row.rx, pred);
        if (cur_row.typed) frame_result_q.push_back(cur_row.res);
        else if (hit) frame_result_q.push_back(pred);
      end
      if (!in_valid || !in_stall) begin
        if (stim_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= GAP_PCT)) begin
          cur_row = stim_q.pop_front();
          in_valid   <= 1'b1;
          in_rx_byte <= cur_row.rx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : take_results
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !no_gaps && ($urandom_range(0, 99) < GAP_PCT);
      if (out_valid && !out_stall) begin
        got = '{out_payload_byte, out_payload_index, out_is_end, out_frame_ok,
                out_seq_number, out_command, out_payload_length};
        if (frame_result_q.size() == 0) begin
          report_error("result item with none expected");
        end else begin
          want = frame_result_q.pop_front();
          check_field("payload_byte", got.payload_byte, want.payload_byte);
          check_field("payload_index", got.payload_index, want.payload_index);
          check_field("is_end", got.is_end, want.is_end);
          check_field("frame_ok", got.frame_ok, want.frame_ok);
          check_field("seq_number", got.seq_number, want.seq_number);
          check_field("command", got.command, want.command);
          check_field("payload_length", got.payload_length, want.payload_length);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin : main_seq
    logic [BYTE_W-1:0] sync_val;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset register values.
    foreach (DIRECTED_ROWS[i]) stim_q.push_back(DIRECTED_ROWS[i]);
    queue_random_traffic(70);
    wait_idle();

    // Extreme values; the unused index must not disturb anything.
    write_reg(CFG_SYNC_FIRST, 8'h00);
    write_reg(CFG_SYNC_SECOND, 8'hFF);
    write_reg(CFG_EXP_VERSION, 8'hFF);
    write_reg(CFG_UNUSED, 8'h5A);
    queue_random_traffic(25);
    queue_frame(MAX_PAYLOAD, 1'b0, 1'b0, 0);
    queue_random_traffic(25);
    wait_idle();

    // Opposite extremes with both channels running back to back.
    write_reg(CFG_SYNC_FIRST, 8'hFF);
    write_reg(CFG_SYNC_SECOND, 8'h00);
    write_reg(CFG_EXP_VERSION, 8'h00);
    no_gaps = 1'b1;
    queue_random_traffic(55);
    wait_idle();
    no_gaps = 1'b0;

    // Both sync bytes equal: the second-sync test must win.
    sync_val = BYTE_W'($urandom);
    write_reg(CFG_SYNC_FIRST, sync_val);
    write_reg(CFG_SYNC_SECOND, sync_val);
    write_reg(CFG_EXP_VERSION, BYTE_W'($urandom));
    queue_random_traffic(55);
    wait_idle();

    write_reg(CFG_SYNC_FIRST, BYTE_W'($urandom));
    write_reg(CFG_SYNC_SECOND, BYTE_W'($urandom));
    write_reg(CFG_EXP_VERSION, BYTE_W'($urandom));
    queue_random_traffic(45);
    wait_idle();

    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
